>>> src/tql_pkg.sv
// Shared types and codes for the timer queue with lazy cancel.
`timescale 1ns / 1ps
package tql_pkg;

  localparam logic [1:0] MODE_SCHEDULE = 2'd0;
  localparam logic [1:0] MODE_CANCEL   = 2'd1;
  localparam logic [1:0] MODE_ADVANCE  = 2'd2;
  localparam logic [1:0] MODE_REARM    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_PENDING = 2'd3;

  localparam int unsigned ID_BITS = 32;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_LAST  = 7'b0000100,
    S_DEC   = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_FIRE  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

endpackage

>>> src/tql_slot_mem.sv
// Slot memory holding due time and id per timer, with a registered read port.
`timescale 1ns / 1ps
module tql_slot_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/timer_queue_lazy_cancel_unit.sv
// Top level of the timer queue with lazy cancel.
`timescale 1ns / 1ps
// Timer table ordered by due time. Drive start with a request while busy is
// low; results appear on result_valid_o for one cycle each and cannot be
// stalled, last_o marking the final one. Every request scans the slot memory
// one entry per cycle through its single read port. Schedule, cancel and
// rearm keep busy high through one scan and the decide and write states,
// and their result shows in the cycle busy drops. Advance repeats a full scan
// for each removed entry, cancelled ones included, plus a final scan that
// finds none due. A fired id is reported one pass after it is found so that
// the final one can carry last_o. No clearing pass is needed after reset.
module timer_queue_lazy_cancel_unit #(
  parameter int unsigned TIMER_SLOTS = 16,
  parameter int unsigned TIME_BITS   = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           mode_i,
  input  logic [31:0]          timer_id_i,
  input  logic [TIME_BITS-1:0] time_value_i,
  input  logic [TIME_BITS-1:0] rearm_interval_i,
  output logic                 result_valid_o,
  output logic [1:0]           status_o,
  output logic [31:0]          result_id_o,
  output logic                 fired_o,
  output logic [$clog2(TIMER_SLOTS+1)-1:0] pending_count_o,
  output logic [TIME_BITS-1:0] current_time_o,
  output logic                 last_o
);

  localparam int unsigned IW = tql_pkg::ID_BITS;
  localparam int unsigned AW = $clog2(TIMER_SLOTS);
  localparam int unsigned CW = $clog2(TIMER_SLOTS+1);
  localparam int unsigned MW = TIME_BITS + IW;
  localparam logic [AW-1:0] LAST_SLOT = AW'(TIMER_SLOTS-1);

  tql_pkg::state_e state_q, state_d;

  logic [TIMER_SLOTS-1:0] valid_q, canc_q;
  logic [IW-1:0]        next_id_q;
  logic [TIME_BITS-1:0] now_q;
  logic [CW-1:0]        count_q;

  logic [1:0]           mode_q;
  logic [TIME_BITS-1:0] tval_q, ival_q;

  logic [AW-1:0]  rptr_q;     // address being read
  logic [AW-1:0]  cptr_q;     // address of data on rdata
  logic           cval_q;     // rdata holds a slot to compare
  logic           hit_q, best_q, free_q, any_fire_q;
  logic [AW-1:0]  hit_idx_q, best_idx_q, free_idx_q;
  logic [TIME_BITS-1:0] best_due_q;
  logic [IW-1:0]  best_id_q;
  logic [IW-1:0]  key_q;      // id sought during the scan
  logic           first_q;    // first pass of an advance
  logic [CW-1:0]  exp_cnt_q;  // entries due, counted on the first pass
  logic [IW-1:0]  hold_id_q;  // fired id not yet reported
  logic           canc_q_was_q;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [MW-1:0]  wdata, rdata;
  logic [TIME_BITS-1:0] r_due;
  logic [IW-1:0]  r_id;
  logic [TIME_BITS:0] sum;

  tql_slot_mem #(.DEPTH(TIMER_SLOTS), .WIDTH(MW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rptr_q),
    .rdata_o(rdata)
  );

  assign r_due = rdata[MW-1:IW];
  assign r_id  = rdata[IW-1:0];
  assign busy  = (state_q != tql_pkg::S_IDLE);
  assign sum   = {1'b0, now_q} + {1'b0, ival_q};
  assign pending_count_o = count_q;
  assign current_time_o  = now_q;

  always_comb begin
    we    = 1'b0;
    waddr = free_idx_q;
    wdata = {tval_q, key_q};
    if (state_q == tql_pkg::S_WRITE && mode_q == tql_pkg::MODE_REARM) begin
      wdata = {(sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0]), key_q};
    end
    if (state_q == tql_pkg::S_WRITE && !hit_q && free_q) begin
      we = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tql_pkg::S_IDLE:  if (start) state_d = tql_pkg::S_SCAN;
      tql_pkg::S_SCAN:  if (rptr_q == LAST_SLOT) state_d = tql_pkg::S_LAST;
      tql_pkg::S_LAST:  state_d = tql_pkg::S_DEC;
      tql_pkg::S_DEC: begin
        if (mode_q == tql_pkg::MODE_ADVANCE) begin
          state_d = best_q ? tql_pkg::S_FIRE : tql_pkg::S_DONE;
        end else begin
          state_d = tql_pkg::S_WRITE;
        end
      end
      tql_pkg::S_WRITE: state_d = tql_pkg::S_IDLE;
      tql_pkg::S_FIRE:  state_d = tql_pkg::S_SCAN;
      tql_pkg::S_DONE:  state_d = tql_pkg::S_IDLE;
      default:          state_d = tql_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= tql_pkg::S_IDLE;
      valid_q        <= '0;
      canc_q         <= '0;
      next_id_q      <= IW'(1);
      now_q          <= '0;
      count_q        <= '0;
      result_valid_o <= 1'b0;
      any_fire_q     <= 1'b0;
      first_q        <= 1'b0;
      cval_q         <= 1'b0;
      rptr_q         <= '0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= 1'b0;
      cptr_q         <= rptr_q;
      cval_q         <= (state_q == tql_pkg::S_SCAN);
      if (state_q == tql_pkg::S_SCAN && rptr_q != LAST_SLOT) begin
        rptr_q <= rptr_q + AW'(1);
      end
      // compare the slot read in the previous cycle
      if (cval_q && valid_q[cptr_q]) begin
        if (r_id == key_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= cptr_q;
        end
        if (r_due <= now_q && (!best_q || r_due < best_due_q ||
            (r_due == best_due_q && r_id < best_id_q))) begin
          best_q     <= 1'b1;
          best_idx_q <= cptr_q;
          best_due_q <= r_due;
          best_id_q  <= r_id;
        end
        if (first_q && r_due <= now_q) begin
          exp_cnt_q <= exp_cnt_q + CW'(1);
        end
      end
      if (cval_q && !valid_q[cptr_q] && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= cptr_q;
      end
      case (state_q)
        tql_pkg::S_IDLE: begin
          if (start) begin
            mode_q     <= mode_i;
            tval_q     <= time_value_i;
            ival_q     <= rearm_interval_i;
            key_q      <= (mode_i == tql_pkg::MODE_SCHEDULE) ? next_id_q : timer_id_i;
            rptr_q     <= '0;
            hit_q      <= 1'b0;
            best_q     <= 1'b0;
            free_q     <= 1'b0;
            any_fire_q <= 1'b0;
            first_q    <= 1'b1;
            exp_cnt_q  <= '0;
            if (mode_i == tql_pkg::MODE_SCHEDULE) begin
              next_id_q <= (next_id_q == {IW{1'b1}}) ? IW'(1) : next_id_q + IW'(1);
            end
            if (mode_i == tql_pkg::MODE_ADVANCE && time_value_i > now_q) begin
              now_q <= time_value_i;
            end
          end
        end
        tql_pkg::S_DEC: begin
          // drop every due entry from the count at once
          if (mode_q == tql_pkg::MODE_ADVANCE && first_q) begin
            count_q <= count_q - exp_cnt_q;
            first_q <= 1'b0;
          end
          if (mode_q == tql_pkg::MODE_ADVANCE && best_q) begin
            valid_q[best_idx_q] <= 1'b0;
            canc_q[best_idx_q]  <= 1'b0;
          end
        end
        tql_pkg::S_WRITE: begin
          result_valid_o <= 1'b1;
          last_o         <= 1'b1;
          fired_o        <= 1'b0;
          result_id_o    <= key_q;
          status_o       <= tql_pkg::ST_OK;
          case (mode_q)
            tql_pkg::MODE_SCHEDULE: begin
              if (!free_q) begin
                status_o    <= tql_pkg::ST_FULL;
                result_id_o <= '0;
                next_id_q   <= key_q;   // undo: no id consumed
              end else if (hit_q) begin
                status_o <= tql_pkg::ST_PENDING;
              end
            end
            tql_pkg::MODE_CANCEL: begin
              if (hit_q) canc_q[hit_idx_q] <= 1'b1;
              else status_o <= tql_pkg::ST_UNKNOWN;
            end
            tql_pkg::MODE_REARM: begin
              if (key_q == '0)  status_o <= tql_pkg::ST_UNKNOWN;
              else if (hit_q)   status_o <= tql_pkg::ST_PENDING;
              else if (!free_q) status_o <= tql_pkg::ST_FULL;
            end
            default: status_o <= tql_pkg::ST_OK;
          endcase
          if (we && !(mode_q == tql_pkg::MODE_REARM && key_q == '0) &&
              mode_q != tql_pkg::MODE_CANCEL) begin
            valid_q[free_idx_q] <= 1'b1;
            canc_q[free_idx_q]  <= 1'b0;
            count_q             <= count_q + CW'(1);
          end
        end
        tql_pkg::S_FIRE: begin
          // if this one is live, report the previous live one and hold this one; then rescan
          if (!canc_q_was_q) begin
            if (any_fire_q) begin
              result_valid_o <= 1'b1;
              status_o       <= tql_pkg::ST_OK;
              result_id_o    <= hold_id_q;
              fired_o        <= 1'b1;
              last_o         <= 1'b0;
            end
            any_fire_q <= 1'b1;
            hold_id_q  <= best_id_q;
          end
          rptr_q <= '0;
          best_q <= 1'b0;
        end
        tql_pkg::S_DONE: begin
          result_valid_o <= 1'b1;
          status_o       <= tql_pkg::ST_OK;
          last_o         <= 1'b1;
          if (any_fire_q) begin
            result_id_o <= hold_id_q;
            fired_o     <= 1'b1;
          end else begin
            result_id_o <= '0;
            fired_o     <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // cancelled flag of the entry removed in the decide cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canc_q_was_q <= 1'b0;
    end else if (state_q == tql_pkg::S_DEC) begin
      canc_q_was_q <= canc_q[best_idx_q];
    end
  end

endmodule

>>> test/tb_timer_queue_lazy_cancel_unit.sv
// Testbench for the timer queue with lazy cancel: predicts every result and checks it.
`timescale 1ns / 1ps
module tb_timer_queue_lazy_cancel_unit;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned TBITS = 48;
  localparam logic [TBITS-1:0] TIME_MAX = {TBITS{1'b1}};
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      id;
    logic             fired;
    logic [4:0]       pending;
    logic [TBITS-1:0] now;
    logic             last;
  } timer_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       mode_i = tql_pkg::MODE_ADVANCE;
  logic [31:0]      timer_id_i = '0;
  logic [TBITS-1:0] time_value_i = '0;
  logic [TBITS-1:0] rearm_interval_i = '0;
  logic             result_valid_o;
  logic [1:0]       status_o;
  logic [31:0]      result_id_o;
  logic             fired_o;
  logic [4:0]       pending_count_o;
  logic [TBITS-1:0] current_time_o;
  logic             last_o;

  // shadow of the timer table
  logic [31:0]      next_id;
  logic [TBITS-1:0] now_shadow;
  logic [TBITS-1:0] tbl_due [SLOTS];
  logic [31:0]      tbl_id [SLOTS];
  logic             tbl_cancel [SLOTS];
  logic             tbl_valid [SLOTS];

  timer_result_t    expected_results[$];
  logic [31:0]      fired_ids[$];
  logic [31:0]      last_sched_id;
  int unsigned      cycles = 0;
  int unsigned      fail_count = 0;
  int unsigned      items_sent = 0;
  int unsigned      results_seen = 0;
  bit               allow_gaps = 1'b1;

  timer_queue_lazy_cancel_unit #(.TIMER_SLOTS(SLOTS), .TIME_BITS(TBITS)) dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .timer_id_i, .time_value_i,
    .rearm_interval_i, .result_valid_o, .status_o, .result_id_o, .fired_o,
    .pending_count_o, .current_time_o, .last_o
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int held_timers();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (tbl_valid[i]) n++;
    return n;
  endfunction

  function automatic int slot_of(logic [31:0] id);
    for (int i = 0; i < SLOTS; i++) if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < SLOTS; i++) if (!tbl_valid[i]) return i;
    return -1;
  endfunction

  function automatic void queue_result(logic [1:0] st, logic [31:0] id, logic fd,
                                       logic lst);
    timer_result_t r;
    r.status  = st;
    r.id      = id;
    r.fired   = fd;
    r.pending = 5'(held_timers());
    r.now     = now_shadow;
    r.last    = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void put_timer(int s, logic [31:0] id, logic [TBITS-1:0] due);
    tbl_valid[s]  = 1'b1;
    tbl_cancel[s] = 1'b0;
    tbl_id[s]     = id;
    tbl_due[s]    = due;
  endfunction

  // work out the results of one accepted request
  function automatic void predict_request(logic [1:0] md, logic [31:0] id,
                                          logic [TBITS-1:0] tv,
                                          logic [TBITS-1:0] iv);
    int s, best;
    logic [31:0] nid;
    logic [TBITS:0] sum;
    logic [31:0] expired[$];
    case (md)
      tql_pkg::MODE_SCHEDULE: begin
        s = free_slot();
        if (s < 0) begin
          queue_result(tql_pkg::ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          nid = next_id;
          next_id = (next_id == 32'hFFFF_FFFF) ? 32'd1 : next_id + 32'd1;
          if (slot_of(nid) >= 0) begin
            queue_result(tql_pkg::ST_PENDING, nid, 1'b0, 1'b1);
          end else begin
            put_timer(s, nid, tv);
            last_sched_id = nid;
            queue_result(tql_pkg::ST_OK, nid, 1'b0, 1'b1);
          end
        end
      end
      tql_pkg::MODE_CANCEL: begin
        s = slot_of(id);
        if (s < 0) begin
          queue_result(tql_pkg::ST_UNKNOWN, id, 1'b0, 1'b1);
        end else begin
          tbl_cancel[s] = 1'b1;
          queue_result(tql_pkg::ST_OK, id, 1'b0, 1'b1);
        end
      end
      tql_pkg::MODE_REARM: begin
        if (id == '0) queue_result(tql_pkg::ST_UNKNOWN, id, 1'b0, 1'b1);
        else if (slot_of(id) >= 0) queue_result(tql_pkg::ST_PENDING, id, 1'b0, 1'b1);
        else if (free_slot() < 0) queue_result(tql_pkg::ST_FULL, id, 1'b0, 1'b1);
        else begin
          sum = {1'b0, now_shadow} + {1'b0, iv};
          put_timer(free_slot(), id, sum[TBITS] ? TIME_MAX : sum[TBITS-1:0]);
          queue_result(tql_pkg::ST_OK, id, 1'b0, 1'b1);
        end
      end
      default: begin
        if (tv > now_shadow) now_shadow = tv;
        forever begin
          best = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (!tbl_valid[i] || tbl_due[i] > now_shadow) continue;
            if (best < 0 || tbl_due[i] < tbl_due[best] ||
                (tbl_due[i] == tbl_due[best] && tbl_id[i] < tbl_id[best]))
              best = i;
          end
          if (best < 0) break;
          tbl_valid[best] = 1'b0;
          if (!tbl_cancel[best]) expired.push_back(tbl_id[best]);
          tbl_cancel[best] = 1'b0;
        end
        if (expired.size() == 0) queue_result(tql_pkg::ST_OK, '0, 1'b0, 1'b1);
        foreach (expired[k]) begin
          queue_result(tql_pkg::ST_OK, expired[k], 1'b1, k == expired.size() - 1);
          fired_ids.push_back(expired[k]);
        end
      end
    endcase
  endfunction

  // compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    timer_result_t want, got;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      got = '{status_o, result_id_o, fired_o, pending_count_o, current_time_o, last_o};
      if (expected_results.size() == 0) begin
        fail_count++;
        $display("%0t unexpected result: expected none, actual %p", $time, got);
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status) begin
          fail_count++;
          $display("%0t status: expected %0d, actual %0d", $time, want.status, got.status);
        end
        if (got.id != want.id) begin
          fail_count++;
          $display("%0t result_id: expected %0h, actual %0h", $time, want.id, got.id);
        end
        if (got.fired != want.fired) begin
          fail_count++;
          $display("%0t fired: expected %0b, actual %0b", $time, want.fired, got.fired);
        end
        if (got.pending != want.pending) begin
          fail_count++;
          $display("%0t pending_count: expected %0d, actual %0d", $time, want.pending,
                   got.pending);
        end
        if (got.now != want.now) begin
          fail_count++;
          $display("%0t current_time: expected %0h, actual %0h", $time, want.now, got.now);
        end
        if (got.last != want.last) begin
          fail_count++;
          $display("%0t last: expected %0b, actual %0b", $time, want.last, got.last);
        end
      end
    end
  end

  task automatic send_request(logic [1:0] md, logic [31:0] id, logic [TBITS-1:0] tv,
                              logic [TBITS-1:0] iv);
    if (allow_gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) @(negedge clk_i);
    @(negedge clk_i);
    start = 1'b1;
    mode_i = md;
    timer_id_i = id;
    time_value_i = tv;
    rearm_interval_i = iv;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predict_request(md, id, tv, iv);
    items_sent++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    send_request(tql_pkg::MODE_SCHEDULE, '0, 48'd5, '0);
    send_request(tql_pkg::MODE_SCHEDULE, 32'hFFFF_FFFF, 48'd0, '0);  // already due
    send_request(tql_pkg::MODE_SCHEDULE, '0, TIME_MAX, '0);
    send_request(tql_pkg::MODE_CANCEL, 32'd1, '0, '0);
    send_request(tql_pkg::MODE_CANCEL, 32'd1, '0, '0);               // cancel twice
    send_request(tql_pkg::MODE_CANCEL, 32'hFFFF_FFFF, '0, '0);       // unknown id
    send_request(tql_pkg::MODE_REARM, 32'd0, '0, 48'd3);
    send_request(tql_pkg::MODE_REARM, 32'd2, '0, 48'd3);             // still pending
    send_request(tql_pkg::MODE_REARM, 32'd1, '0, 48'd3);             // cancelled, still held
    send_request(tql_pkg::MODE_ADVANCE, '0, 48'd10, '0);
    send_request(tql_pkg::MODE_ADVANCE, '0, 48'd3, '0);              // must not go back
    send_request(tql_pkg::MODE_REARM, 32'd1, '0, 48'd0);             // zero interval
    send_request(tql_pkg::MODE_REARM, 32'hFFFF_FFFF, '0, TIME_MAX);  // saturate
    send_request(tql_pkg::MODE_ADVANCE, '0, 48'd10, '0);
    // fill the table with equal due times, then overflow it
    for (int i = 0; i < 14; i++) send_request(tql_pkg::MODE_SCHEDULE, '0, 48'd100, '0);
    send_request(tql_pkg::MODE_SCHEDULE, '0, 48'd7, '0);
    send_request(tql_pkg::MODE_REARM, 32'd2, '0, 48'd1);
    send_request(tql_pkg::MODE_ADVANCE, '0, 48'd200, '0);
  endtask

  function automatic logic [TBITS-1:0] rand_wide();
    return TBITS'({$urandom(), $urandom()});
  endfunction

  task automatic test_random_mix(int n);
    logic [31:0] id;
    logic [TBITS-1:0] tv, iv;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (k == n / 2) begin
        wait_drained();
        repeat ($urandom_range(5, 30)) @(negedge clk_i);
      end
      if (pick < 40) begin
        tv = ($urandom_range(0, 7) == 0) ? rand_wide() : now_shadow + $urandom_range(0, 60);
        send_request(tql_pkg::MODE_SCHEDULE, $urandom(), tv, rand_wide());
      end else if (pick < 55) begin
        id = ($urandom_range(0, 3) == 0) ? $urandom() : last_sched_id - $urandom_range(0, 4);
        send_request(tql_pkg::MODE_CANCEL, id, rand_wide(), rand_wide());
      end else if (pick < 80) begin
        send_request(tql_pkg::MODE_ADVANCE, $urandom(), now_shadow + $urandom_range(0, 50),
                     rand_wide());
      end else begin
        if (fired_ids.size() != 0 && $urandom_range(0, 3) != 0)
          id = fired_ids[$urandom_range(0, fired_ids.size() - 1)];
        else
          id = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom();
        iv = ($urandom_range(0, 7) == 0) ? rand_wide() : 48'($urandom_range(0, 40));
        send_request(tql_pkg::MODE_REARM, id, rand_wide(), iv);
      end
    end
  endtask

  task automatic test_time_extremes();
    send_request(tql_pkg::MODE_ADVANCE, '0, TIME_MAX - 48'd2, '0);
    send_request(tql_pkg::MODE_REARM, 32'h8000_0000, '0, 48'd1);
    send_request(tql_pkg::MODE_REARM, 32'h7FFF_FFFF, '0, 48'd9);   // saturates
    send_request(tql_pkg::MODE_SCHEDULE, '0, 48'd1, '0);
    send_request(tql_pkg::MODE_ADVANCE, '0, TIME_MAX, '0);
    send_request(tql_pkg::MODE_ADVANCE, '0, '0, '0);
  endtask

  initial begin
    int unsigned guard;
    next_id = 32'd1;
    now_shadow = '0;
    last_sched_id = 32'd1;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_cancel[i] = 1'b0;
      tbl_due[i] = '0;
      tbl_id[i] = '0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_cases();
    test_random_mix(150);
    allow_gaps = 1'b0;
    test_random_mix(25);
    test_time_extremes();
    guard = 0;
    while (expected_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (400) @(posedge clk_i);
    $display("Sent %0d requests (schedule, cancel, advance, rearm) and checked %0d results,",
             items_sent, results_seen);
    $display("covering full table, unknown and pending ids, ties, past dues and saturation.");
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count,
               expected_results.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
